// ===== hdl/hcsf_pkg.sv =====
package hcsf_pkg;

   localparam int H_W        = 16;
   localparam int REGION_W   = 10;
   localparam int SIDE_CFG_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int WIN_N      = 5;
   localparam int W_W        = 16;
   localparam int RECIP_W    = 16;
   localparam int WSUM_W     = 20;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_MAP_SIDE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_FIRST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COL_LAST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_FIRST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_LAST   = 3'd4;

   // edge patterns of the window along one axis
   localparam logic [2:0] PAT_FIRST  = 3'd0;
   localparam logic [2:0] PAT_SECOND = 3'd1;
   localparam logic [2:0] PAT_INNER  = 3'd2;
   localparam logic [2:0] PAT_PENULT = 3'd3;
   localparam logic [2:0] PAT_LAST   = 3'd4;

   typedef struct packed {
      logic           operation;
      logic [H_W-1:0] height_in;
   } req_type;

   typedef struct packed {
      logic [H_W-1:0]      smoothed_height;
      logic [REGION_W-1:0] out_col;
      logic [REGION_W-1:0] out_row;
      logic                region_done;
   } rsp_type;

   typedef logic [WIN_N-1:0][H_W-1:0] col_type;

   localparam logic [W_W-1:0] CONE_W [WIN_N][WIN_N] = '{
      '{16'd3748,  16'd16688, 16'd21845, 16'd16688, 16'd3748},
      '{16'd16688, 16'd34642, 16'd43691, 16'd34642, 16'd16688},
      '{16'd21845, 16'd43691, 16'd65535, 16'd43691, 16'd21845},
      '{16'd16688, 16'd34642, 16'd43691, 16'd34642, 16'd16688},
      '{16'd3748,  16'd16688, 16'd21845, 16'd16688, 16'd3748}
   };

   function automatic logic [WIN_N-1:0] pat_mask(input logic [2:0] pat);
      logic [WIN_N-1:0] m;
      unique case (pat)
         PAT_FIRST:  m = 5'b11100;
         PAT_SECOND: m = 5'b11110;
         PAT_PENULT: m = 5'b01111;
         PAT_LAST:   m = 5'b00111;
         default:    m = 5'b11111;
      endcase
      return m;
   endfunction

   // rounded 2^32 / weight sum, indexed by row pattern * 5 + column pattern
   localparam logic [RECIP_W-1:0] RECIP_TABLE [WIN_N*WIN_N] = '{
      16'd16004, 16'd11819, 16'd10587, 16'd11819, 16'd16004,
      16'd11819, 16'd8711,  16'd7780,  16'd8711,  16'd11819,
      16'd10587, 16'd7780,  16'd6987,  16'd7780,  16'd10587,
      16'd11819, 16'd8711,  16'd7780,  16'd8711,  16'd11819,
      16'd16004, 16'd11819, 16'd10587, 16'd11819, 16'd16004
   };

endpackage

// ===== hdl/heightmap_cone_smoothing_filter.sv =====
// 5x5 cone smoothing filter for a square heightmap sent in raster order, followed by
// 2*side+2 flush transfers to push out the last rows. Results lag the input by two rows
// and two vertices and cover only the configured rectangle. The window is a row of five
// column cells; an item that yields a vertex goes through line store read, five steps
// of the window rotating past a row of five multipliers, accumulate, normalise and blend,
// one that yields none through the read alone, and an early flush is taken in idle. The
// line store is four single-port-write RAMs of MAX_SIDE entries with registered reads.
module heightmap_cone_smoothing_filter #(
   parameter int MAX_SIDE    = 1024,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  hcsf_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output hcsf_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [hcsf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hcsf_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import hcsf_pkg::*;

   localparam int SW       = $clog2(MAX_SIDE + 1);
   localparam int CW       = $clog2(MAX_SIDE);
   localparam int RW       = $clog2(MAX_SIDE + 3);
   localparam int XW       = RW + 2;
   localparam int SIDE_RST = (MAX_SIDE < 1024) ? MAX_SIDE : 1024;
   localparam int PW       = W_W + H_W;
   localparam int ACC_W    = WSUM_W + H_W;
   localparam int MW       = ACC_W + RECIP_W;
   localparam logic [H_W:0]   HLIM = (17'd1 << HEIGHT_BITS) - 17'd1;
   localparam logic [H_W-1:0] HMAX = HLIM[H_W-1:0];

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_MAC  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]          state_ff;
   logic [2:0]          cnt_ff;
   logic [SW-1:0]       side_ff;
   logic [REGION_W-1:0] rcf_ff, rcl_ff, rrf_ff, rrl_ff;
   logic [CW-1:0]       scan_col_ff;
   logic [RW-1:0]       scan_row_ff;
   logic [H_W-1:0]      val_ff;
   logic [WIN_N-1:0]    rmask_ff, cmask_ff;
   logic [4:0]          ridx_in, ridx_ff;
   logic [REGION_W-1:0] ocol_ff, orow_ff;
   logic                done_ff;
   logic [WIN_N-1:0][PW-1:0] prod_ff;
   logic                pend_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [H_W-1:0]      h_ff;
   logic [RECIP_W-1:0]  recip_ff;
   logic [MW-1:0]       mprod_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                accept, cfg_we;
   logic                in_map;
   logic [3:0][H_W-1:0] rd;
   col_type             new_col;
   col_type             cell_q [WIN_N];
   col_type             cell_d [WIN_N];
   logic                shift;

   logic [XW-1:0] r_x, c_x, s_x, cr_x, cc_x, cl_x, rl_x;
   logic          cr_ok, emit;
   logic [2:0]    rp, cp;
   logic [ACC_W-1:0] acc_in;
   logic [MW:0]      total;
   logic [MW-16:0]   blend;
   logic [H_W-1:0]   res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid && csr_ready;
   assign in_map    = (RW'(scan_row_ff) < RW'(side_ff));

   // line store
   for (genvar g = 0; g < 4; g++) begin : g_line
      hcsf_ram #(.WIDTH(H_W), .DEPTH(MAX_SIDE)) u_ram (
         .clock (clock),
         .we    ((state_ff == S_READ) && (scan_row_ff[1:0] == 2'(g))),
         .waddr (scan_col_ff),
         .wdata (val_ff),
         .raddr (scan_col_ff),
         .rdata (rd[g])
      );
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         new_col[k] = rd[2'(scan_row_ff[1:0] + 2'(k))];
      end
      new_col[4] = val_ff;
   end

   // window: chain of column cells, rotating during the accumulate walk
   assign shift = (state_ff == S_READ) || (state_ff == S_MAC);
   for (genvar g = 0; g < WIN_N; g++) begin : g_win
      if (g == WIN_N - 1) begin : g_tail
         assign cell_d[g] = (state_ff == S_MAC) ? cell_q[0] : new_col;
      end else begin : g_body
         assign cell_d[g] = cell_q[g+1];
      end
      hcsf_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .col_in  (cell_d[g]),
         .col_out (cell_q[g])
      );
   end

   // centre position and region test
   always_comb begin
      r_x  = XW'(scan_row_ff);
      c_x  = XW'(scan_col_ff);
      s_x  = XW'(side_ff);
      cl_x = (XW'(rcl_ff) > s_x - XW'(1)) ? s_x - XW'(1) : XW'(rcl_ff);
      rl_x = (XW'(rrl_ff) > s_x - XW'(1)) ? s_x - XW'(1) : XW'(rrl_ff);
      if (c_x >= XW'(2)) begin
         cr_ok = (r_x >= XW'(2));
         cr_x  = r_x - XW'(2);
         cc_x  = c_x - XW'(2);
      end else begin
         cr_ok = (r_x >= XW'(3));
         cr_x  = r_x - XW'(3);
         cc_x  = s_x - XW'(2) + c_x;
      end
      emit = cr_ok && (cr_x < s_x) && (cc_x >= XW'(rcf_ff)) && (cc_x <= cl_x)
             && (cr_x >= XW'(rrf_ff)) && (cr_x <= rl_x);
      if (cr_x == XW'(0))               rp = PAT_FIRST;
      else if (cr_x == XW'(1))          rp = PAT_SECOND;
      else if (cr_x == s_x - XW'(1))    rp = PAT_LAST;
      else if (cr_x == s_x - XW'(2))    rp = PAT_PENULT;
      else                              rp = PAT_INNER;
      if (cc_x == XW'(0))               cp = PAT_FIRST;
      else if (cc_x == XW'(1))          cp = PAT_SECOND;
      else if (cc_x == s_x - XW'(1))    cp = PAT_LAST;
      else if (cc_x == s_x - XW'(2))    cp = PAT_PENULT;
      else                              cp = PAT_INNER;
      ridx_in = 5'(rp) * 5'd5 + 5'(cp);
   end

   always_comb begin
      acc_in = acc_ff;
      if (pend_ff) begin
         for (int k = 0; k < WIN_N; k++) begin
            acc_in = acc_in + ACC_W'(prod_ff[k]);
         end
      end
      total = (MW+1)'({h_ff, 16'h0000}) + (MW+1)'(mprod_ff >> 16);
      blend = (MW-15)'(total >> 17);
      res   = (blend > (MW-15)'(HMAX)) ? HMAX : blend[H_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         side_ff      <= SW'(SIDE_RST);
         rcf_ff       <= '0;
         rcl_ff       <= '1;
         rrf_ff       <= '0;
         rrl_ff       <= '1;
         scan_col_ff  <= '0;
         scan_row_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= (state_ff == S_MAC);
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg_we) begin
            unique case (csr_index)
               REG_MAP_SIDE: begin
                  if (csr_wdata < 11'd5) begin
                     side_ff <= SW'(5);
                  end else if (32'(csr_wdata) > MAX_SIDE) begin
                     side_ff <= SW'(MAX_SIDE);
                  end else begin
                     side_ff <= SW'(csr_wdata);
                  end
                  scan_col_ff <= '0;
                  scan_row_ff <= '0;
               end
               REG_COL_FIRST: rcf_ff <= csr_wdata[REGION_W-1:0];
               REG_COL_LAST:  rcl_ff <= csr_wdata[REGION_W-1:0];
               REG_ROW_FIRST: rrf_ff <= csr_wdata[REGION_W-1:0];
               REG_ROW_LAST:  rrl_ff <= csr_wdata[REGION_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && !(req_data.operation == OP_FLUSH && in_map)) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if ((r_x == s_x + XW'(2)) && (c_x == XW'(1))) begin
                  scan_row_ff <= '0;
                  scan_col_ff <= '0;
               end else if (c_x + XW'(1) >= s_x) begin
                  scan_col_ff <= '0;
                  scan_row_ff <= scan_row_ff + RW'(1);
               end else begin
                  scan_col_ff <= scan_col_ff + CW'(1);
               end
               cnt_ff   <= '0;
               state_ff <= emit ? S_MAC : S_IDLE;
            end
            S_MAC: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd4) begin
                  state_ff <= S_SUM;
               end
            end
            S_SUM: state_ff <= S_MUL;
            S_MUL: state_ff <= S_FIN;
            S_FIN: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         val_ff <= (req_data.operation == OP_SAMPLE && in_map) ?
                   (req_data.height_in & HMAX) : '0;
      end
      if (state_ff == S_READ) begin
         rmask_ff <= pat_mask(rp);
         cmask_ff <= pat_mask(cp);
         ridx_ff  <= ridx_in;
         ocol_ff  <= REGION_W'(cc_x - XW'(rcf_ff));
         orow_ff  <= REGION_W'(cr_x - XW'(rrf_ff));
         done_ff  <= (cc_x == cl_x) && (cr_x == rl_x);
         acc_ff   <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      if (state_ff == S_MAC) begin
         for (int k = 0; k < WIN_N; k++) begin
            prod_ff[k] <= (rmask_ff[k] && cmask_ff[cnt_ff]) ?
                          PW'(CONE_W[k][cnt_ff]) * PW'(cell_q[0][k]) : '0;
         end
         if (cnt_ff == 3'd0) begin
            h_ff <= cell_q[2][2];
         end
      end
      if (state_ff == S_SUM) begin
         recip_ff <= RECIP_TABLE[ridx_ff];
      end
      if (state_ff == S_MUL) begin
         mprod_ff <= MW'(acc_ff) * MW'(recip_ff);
      end
      if (state_ff == S_FIN && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.smoothed_height <= res;
         rsp_data_ff.out_col         <= ocol_ff;
         rsp_data_ff.out_row         <= orow_ff;
         rsp_data_ff.region_done     <= done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FIN)
      else $error("result raised outside the final step");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MAC |-> cnt_ff <= 3'd4)
      else $error("window walk ran past the last column");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      RW'(scan_col_ff) < RW'(side_ff) || scan_col_ff == '0)
      else $error("scan column beyond the map side");

   a_idle_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_IDLE || state_ff == S_MAC)
      else $error("bad step after line store read");

endmodule

// ===== hdl/hcsf_ram.sv =====
module hcsf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/hcsf_cell.sv =====
module hcsf_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            shift,
   input  hcsf_pkg::col_type col_in,
   output hcsf_pkg::col_type col_out
);
   import hcsf_pkg::*;

   col_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

// ===== tb/sv/hcsf_checker.sv =====
`timescale 1ns / 1ps

module hcsf_checker
   import hcsf_pkg::*;
#(
   parameter int MAX_SIDE = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   logic [SIDE_CFG_W-1:0] side_reg;
   logic [REGION_W-1:0]   col_first, col_last, row_first, row_last;
   logic [H_W-1:0]        line_mem [0:4*MAX_SIDE-1];
   logic [H_W-1:0]        win [0:4][0:4];
   int                    scan_c, scan_r;
   rsp_type               smoothed_q [$];

   function automatic int side_limited();
      int s;
      s = int'(side_reg);
      if (s < 5) s = 5;
      if (s > MAX_SIDE) s = MAX_SIDE;
      return s;
   endfunction

   function automatic logic [H_W-1:0] cone_blend(input int cr, input int cc, input int s);
      longint unsigned acc, wsum, recip, mean, blend;
      int              rr, c2;
      acc  = 0;
      wsum = 0;
      for (int dr = -2; dr <= 2; dr++) begin
         for (int dc = -2; dc <= 2; dc++) begin
            rr = cr + dr;
            c2 = cc + dc;
            if (rr >= 0 && rr < s && c2 >= 0 && c2 < s) begin
               acc  += longint'(CONE_W[dr+2][dc+2]) * longint'(win[dr+2][dc+2]);
               wsum += longint'(CONE_W[dr+2][dc+2]);
            end
         end
      end
      recip = ((64'd1 << 32) + (wsum >> 1)) / wsum;
      mean  = (acc * recip) >> 16;
      blend = ((longint'(win[2][2]) << 16) + mean) >> 17;
      if (blend > 65535) blend = 65535;
      return blend[H_W-1:0];
   endfunction

   task automatic advance_window(input req_type item);
      int               s, r, c, cr, cc, cl, rl;
      logic             in_map;
      logic [H_W-1:0]   val;
      logic [H_W-1:0]   col [0:4];
      rsp_type          res;
      s      = side_limited();
      r      = scan_r;
      c      = scan_c;
      in_map = r < s;
      if (item.operation == OP_FLUSH && in_map) return;
      val = (item.operation == OP_SAMPLE && in_map) ? item.height_in : '0;
      for (int k = 0; k < 4; k++) col[k] = line_mem[((r + k) & 3) * MAX_SIDE + c];
      col[4] = val;
      for (int k = 0; k < 5; k++) begin
         for (int j = 0; j < 4; j++) win[k][j] = win[k][j+1];
         win[k][4] = col[k];
      end
      line_mem[(r & 3) * MAX_SIDE + c] = val;
      if (c >= 2) begin
         cr = r - 2;
         cc = c - 2;
      end else begin
         cr = r - 3;
         cc = s - 2 + c;
      end
      cl = (int'(col_last) > s - 1) ? s - 1 : int'(col_last);
      rl = (int'(row_last) > s - 1) ? s - 1 : int'(row_last);
      if (cr >= 0 && cr < s && cc >= 0 && cc < s && cc >= int'(col_first) && cc <= cl &&
          cr >= int'(row_first) && cr <= rl) begin
         res.smoothed_height = cone_blend(cr, cc, s);
         res.out_col         = REGION_W'(cc - int'(col_first));
         res.out_row         = REGION_W'(cr - int'(row_first));
         res.region_done     = (cc == cl && cr == rl);
         smoothed_q.push_back(res);
      end
      if (r == s + 2 && c == 1) begin
         scan_r = 0;
         scan_c = 0;
      end else begin
         c++;
         if (c >= s) begin
            c = 0;
            r++;
         end
         scan_c = c;
         scan_r = r & 11'h7FF;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (smoothed_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected transfer: height %0d col %0d row %0d done %0b",
                     got.smoothed_height, got.out_col, got.out_row, got.region_done);
         return;
      end
      want = smoothed_q.pop_front();
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch: expected h %0d c %0d r %0d d %0b, got h %0d c %0d r %0d d %0b",
                     want.smoothed_height, want.out_col, want.out_row, want.region_done,
                     got.smoothed_height, got.out_col, got.out_row, got.region_done);
      end
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         side_reg  = 11'd1024;
         col_first = '0;
         col_last  = 10'd1023;
         row_first = '0;
         row_last  = 10'd1023;
         for (int i = 0; i < 4 * MAX_SIDE; i++) line_mem[i] = '0;
         for (int k = 0; k < 5; k++)
            for (int j = 0; j < 5; j++) win[k][j] = '0;
         scan_c = 0;
         scan_r = 0;
         smoothed_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAP_SIDE: begin
                  side_reg = csr_wdata[SIDE_CFG_W-1:0];
                  scan_c   = 0;
                  scan_r   = 0;
               end
               REG_COL_FIRST: col_first = csr_wdata[REGION_W-1:0];
               REG_COL_LAST:  col_last  = csr_wdata[REGION_W-1:0];
               REG_ROW_FIRST: row_first = csr_wdata[REGION_W-1:0];
               REG_ROW_LAST:  row_last  = csr_wdata[REGION_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) advance_window(req_data);
      end
      outstanding = smoothed_q.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import hcsf_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    outstanding;
   int                    cycles;
   int                    hold_cycles;
   bit                    calm;
   int                    sent;

   heightmap_cone_smoothing_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hcsf_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 25);
         end
      end
   end

   task automatic send_item(input logic op, input logic [H_W-1:0] h);
      int gap;
      if (!calm && $urandom_range(0, 99) < 25) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_data.operation <= op;
      req_data.height_in <= h;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_region(input int cf, input int cl, input int rf, input int rl);
      write_reg(REG_COL_FIRST, cf);
      write_reg(REG_COL_LAST, cl);
      write_reg(REG_ROW_FIRST, rf);
      write_reg(REG_ROW_LAST, rl);
   endtask

   function automatic logic [H_W-1:0] pick_height();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return H_W'($urandom);
   endfunction

   // one map with random content, sometimes cut short, sometimes with stray flushes
   task automatic send_map(input int s, input bit broken);
      int n;
      n = broken ? $urandom_range(1, s * s + 2 * s) : s * s + 2 * s + 2;
      for (int i = 0; i < n; i++) begin
         if (i < s * s && $urandom_range(0, 99) < 5) begin
            send_item(OP_FLUSH, H_W'($urandom));
            sent--;
         end
         if (i < s * s) send_item(OP_SAMPLE, pick_height());
         else send_item(logic'($urandom_range(0, 1)), H_W'($urandom));
      end
   endtask

   initial begin
      int s;
      int cf;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      hold_cycles = 0;
      calm        = 1'b0;
      sent        = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed map of side five with extreme heights and early flushes
      write_reg(REG_MAP_SIDE, 5);
      set_region(0, 1023, 0, 1023);
      send_item(OP_FLUSH, 16'hFFFF);
      for (int i = 0; i < 25; i++) begin
         send_item(OP_SAMPLE, (i % 3 == 0) ? 16'h0000 : 16'hFFFF);
         if (i == 12) send_item(OP_FLUSH, 16'h1234);
      end
      for (int i = 0; i < 12; i++) send_item(i[0] ? OP_FLUSH : OP_SAMPLE, 16'hFFFF);
      drain();

      // side below minimum and a small sub-rectangle
      write_reg(REG_MAP_SIDE, 0);
      set_region(1, 3, 2, 2);
      send_map(5, 1'b0);
      drain();

      // empty region
      set_region(4, 2, 0, 1023);
      send_map(5, 1'b0);
      drain();

      // largest side, only the start of the first row
      write_reg(REG_MAP_SIDE, 2047);
      set_region(1020, 1023, 0, 0);
      for (int i = 0; i < 64; i++) send_item(OP_SAMPLE, pick_height());
      drain();

      // result side held off while the sender keeps offering
      write_reg(REG_MAP_SIDE, 8);
      set_region(0, 1023, 0, 1023);
      hold_cycles = 400;
      send_map(8, 1'b0);
      drain();

      while (sent < 1500) begin
         s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
         write_reg(REG_MAP_SIDE, s);
         if (s < 5) s = 5;
         cf = $urandom_range(0, s);
         set_region(cf, ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, s + 2),
                    $urandom_range(0, s), ($urandom_range(0, 3) == 0) ? 1023
                                                              : $urandom_range(0, s + 2));
         calm = ($urandom_range(0, 9) == 0);
         repeat ($urandom_range(1, 3)) send_map(s, $urandom_range(0, 9) == 0);
         drain();
         calm = 1'b0;
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/hcsf_pkg.sv
hdl/hcsf_ram.sv
hdl/hcsf_cell.sv
hdl/heightmap_cone_smoothing_filter.sv
tb/sv/hcsf_checker.sv
tb/sv/testbench.sv
